[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL of the chunk frame parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: invariant violated");

// When the antecedent holds, the consequent must hold at the same edge.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication violated");

`endif

[hw/rtl/cfp_pkg.sv]
// Package with types and constants of the chunk frame parser.
`timescale 1ns / 1ps

package cfp_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned PosWidth   = 4;
   localparam int unsigned IdWidth    = 32;
   localparam int unsigned FieldWidth = 16;

   // Byte positions inside the frame header.
   localparam logic [PosWidth-1:0] PosMagic   = 4'd0;
   localparam logic [PosWidth-1:0] PosId0     = 4'd1;
   localparam logic [PosWidth-1:0] PosId1     = 4'd2;
   localparam logic [PosWidth-1:0] PosId2     = 4'd3;
   localparam logic [PosWidth-1:0] PosId3     = 4'd4;
   localparam logic [PosWidth-1:0] PosIndex0  = 4'd5;
   localparam logic [PosWidth-1:0] PosIndex1  = 4'd6;
   localparam logic [PosWidth-1:0] PosTotal0  = 4'd7;
   localparam logic [PosWidth-1:0] PosTotal1  = 4'd8;
   localparam logic [PosWidth-1:0] PosPayload = 4'd9;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_SHORT     = 2'd1,
      ERR_MAGIC     = 2'd2,
      ERR_BAD_INDEX = 2'd3
   } error_type;

   typedef struct packed {
      kind_type                kind;
      logic [IdWidth-1:0]      session_id;
      logic [FieldWidth-1:0]   chunk_index;
      logic [FieldWidth-1:0]   chunk_total;
      logic [ByteWidth-1:0]    payload_byte;
      error_type               error_code;
      logic                    frame_done;
   } result_type;

endpackage

[hw/rtl/chunk_frame_parser_unit.sv]
// Top level of the chunk frame parser: input stage, frame decode and result register.
// A byte's result passes the input stage and the result register before it shows on the rsp_ channel.
// Throughput: one byte per cycle unless the result stalls, set by the single decode step between
// the input stage and the result register; a stalled result still leaves room for one more byte.
// Reset (synchronous, active high) empties both stages, clears the frame position,
// the drop flag and the magic register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chunk_frame_parser_unit (
   input  logic        clock,
   input  logic        reset,
   // Input channel: one frame byte per transfer.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_frame_end,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_session_id,
   output logic [15:0] rsp_chunk_index,
   output logic [15:0] rsp_chunk_total,
   output logic [7:0]  rsp_payload_byte,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_frame_done,
   // Configuration: expected magic byte.
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   // The input stage holds one accepted byte. It moves into the decode step
   // whenever the result register is empty or its result is taken in the
   // same cycle, so the input stage frees up and a new transfer can be taken.
   logic                                 in_valid_ff, in_valid_in;
   logic [cfp_pkg::ByteWidth-1:0]        in_byte_ff;
   logic                                 in_end_ff;

   // Parser state. The accumulators are written lane by lane, each lane at least
   // once per frame before the header is checked, so they need no clearing.
   logic [cfp_pkg::PosWidth-1:0]         pos_ff, pos_in;
   logic                                 drop_ff, drop_in;
   logic [cfp_pkg::IdWidth-1:0]          id_ff, id_in;
   logic [cfp_pkg::FieldWidth-1:0]       index_ff, index_in;
   logic [cfp_pkg::FieldWidth-1:0]       total_ff, total_in;
   logic [cfp_pkg::ByteWidth-1:0]        magic_ff;

   // Result register.
   logic                                 rsp_valid_ff, rsp_valid_in;
   cfp_pkg::result_type                  rsp_ff;
   cfp_pkg::result_type                  result;
   logic                                 produce;
   logic                                 out_free;
   logic                                 advance;

   // Flags on the held result, used by the checks at the end.
   logic                                 rsp_is_error;
   logic                                 rsp_has_code;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Decode of the byte in the input stage against the current frame state.
   always_comb begin
      pos_in   = pos_ff;
      drop_in  = drop_ff;
      id_in    = id_ff;
      index_in = index_ff;
      total_in = total_ff;
      produce  = 1'b0;
      result   = '0;
      result.kind       = cfp_pkg::KIND_HEADER;
      result.error_code = cfp_pkg::ERR_NONE;
      result.frame_done = in_end_ff;

      // Place the byte in its header lane.
      case (pos_ff)
         cfp_pkg::PosId0:    id_in[7:0]      = in_byte_ff;
         cfp_pkg::PosId1:    id_in[15:8]     = in_byte_ff;
         cfp_pkg::PosId2:    id_in[23:16]    = in_byte_ff;
         cfp_pkg::PosId3:    id_in[31:24]    = in_byte_ff;
         cfp_pkg::PosIndex0: index_in[7:0]   = in_byte_ff;
         cfp_pkg::PosIndex1: index_in[15:8]  = in_byte_ff;
         cfp_pkg::PosTotal0: total_in[7:0]   = in_byte_ff;
         cfp_pkg::PosTotal1: total_in[15:8]  = in_byte_ff;
         default: ;
      endcase

      if (drop_ff) begin
         // Rest of a failed frame: silent up to and including its last byte.
         if (in_end_ff) begin
            pos_in  = cfp_pkg::PosMagic;
            drop_in = 1'b0;
         end
      end else if (pos_ff >= cfp_pkg::PosPayload) begin
         produce             = 1'b1;
         result.kind         = cfp_pkg::KIND_PAYLOAD;
         result.payload_byte = in_byte_ff;
         pos_in = in_end_ff ? cfp_pkg::PosMagic : cfp_pkg::PosPayload;
      end else if (pos_ff == cfp_pkg::PosMagic) begin
         if (in_end_ff) begin
            // The length check wins over the magic check.
            produce           = 1'b1;
            result.kind       = cfp_pkg::KIND_ERROR;
            result.error_code = cfp_pkg::ERR_SHORT;
         end else if (in_byte_ff != magic_ff) begin
            produce           = 1'b1;
            result.kind       = cfp_pkg::KIND_ERROR;
            result.error_code = cfp_pkg::ERR_MAGIC;
            drop_in           = 1'b1;
         end else begin
            pos_in = cfp_pkg::PosId0;
         end
      end else if (pos_ff != cfp_pkg::PosTotal1) begin
         if (in_end_ff) begin
            produce           = 1'b1;
            result.kind       = cfp_pkg::KIND_ERROR;
            result.error_code = cfp_pkg::ERR_SHORT;
            pos_in            = cfp_pkg::PosMagic;
         end else begin
            pos_in = pos_ff + cfp_pkg::PosWidth'(1);
         end
      end else begin
         // Last header byte: the header is complete and checked here.
         produce = 1'b1;
         if ((total_in == '0) || (index_in >= total_in)) begin
            result.kind       = cfp_pkg::KIND_ERROR;
            result.error_code = cfp_pkg::ERR_BAD_INDEX;
            if (in_end_ff) begin
               pos_in = cfp_pkg::PosMagic;
            end else begin
               drop_in = 1'b1;
            end
         end else begin
            result.kind        = cfp_pkg::KIND_HEADER;
            result.session_id  = id_in;
            result.chunk_index = index_in;
            result.chunk_total = total_in;
            pos_in = in_end_ff ? cfp_pkg::PosMagic : cfp_pkg::PosPayload;
         end
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = produce;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= cfp_pkg::PosMagic;
         drop_ff      <= 1'b0;
         magic_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            magic_ff <= csr_wr_data;
         end
         if (advance) begin
            pos_ff  <= pos_in;
            drop_ff <= drop_in;
         end
      end
   end

   // Payload registers, no reset needed.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_frame_byte;
         in_end_ff  <= req_frame_end;
      end
      if (advance) begin
         id_ff    <= id_in;
         index_ff <= index_in;
         total_ff <= total_in;
      end
      if (advance && produce) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_session_id   = rsp_ff.session_id;
   assign rsp_chunk_index  = rsp_ff.chunk_index;
   assign rsp_chunk_total  = rsp_ff.chunk_total;
   assign rsp_payload_byte = rsp_ff.payload_byte;
   assign rsp_error_code   = rsp_ff.error_code;
   assign rsp_frame_done   = rsp_ff.frame_done;

   assign rsp_is_error = (rsp_ff.kind == cfp_pkg::KIND_ERROR);
   assign rsp_has_code = (rsp_ff.error_code != cfp_pkg::ERR_NONE);

   // The position never runs past the payload position.
   `ASSERT_ALWAYS(a_pos_range, clock, reset, pos_ff <= cfp_pkg::PosPayload)
   // Only a full input stage behind a stalled result may refuse a transfer.
   `ASSERT_IMPLIES(a_ready_low, clock, reset, !req_ready, in_valid_ff && !out_free)
   // An error result always carries an error code.
   `ASSERT_IMPLIES(a_err_code, clock, reset, rsp_valid_ff && rsp_is_error, rsp_has_code)
   // Header and payload results never carry an error code.
   `ASSERT_IMPLIES(a_ok_code, clock, reset, rsp_valid_ff && !rsp_is_error, !rsp_has_code)

endmodule
